/* sv/mrb_pkg.sv */
package mrb_pkg;

  localparam int CFG_W    = 11;
  localparam int WORD_W   = 32;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_PULL  = 2'd1;
  localparam logic [1:0] OP_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]        operation;
    logic [WORD_W-1:0] channel_0_sample;
    logic [WORD_W-1:0] channel_1_sample;
    logic              last_of_group;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] channel_0_word_out;
    logic [WORD_W-1:0] channel_1_word_out;
    logic              last_out;
  } out_item_t;

  // one registered word on its way through the offset logic
  typedef struct packed {
    logic       vld;
    logic [1:0] op;
    logic       last;
  } cmd_t;

endpackage

/* sv/multichannel_overwrite_ring_buffer.sv */
// channel   | ports                            | handshake
// ----------+----------------------------------+-------------------------------
// input     | start, busy, in_data             | word taken when start & !busy
// result    | out_valid, out_data              | one-cycle strobe, no backpressure
// config    | cfg_valid, cfg_ready, cfg_data   | ring length taken on valid & ready
//
// One word per cycle while busy is low: input register, then offset logic and
// one store access. A pull's result strobes after the input register and the
// store's read register. After reset the store is zeroed, one slot a cycle,
// through every slot (busy high). A ring-length write while idle reduces the
// offsets mod the new length, one bit per cycle; busy stays high until it ends.
module multichannel_overwrite_ring_buffer import mrb_pkg::*; #(
  parameter int DEPTH        = 1024,
  parameter int CHANNELS     = 2,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_data,
  output logic             out_valid,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int PW       = $clog2(DEPTH);
  localparam int LW       = $clog2(DEPTH + 1);
  localparam int STORE_CH = (CHANNELS > 1) ? 2 : 1;
  localparam int DW       = STORE_CH * SAMPLE_WIDTH;
  localparam int LEN_RST  = (DEPTH < 1024) ? DEPTH : 1024;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_REDUCE = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [PW-1:0] clr_r, clr_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          cfg_wr, red_start, red_done;

  logic          stg_vld_r;
  logic [1:0]    stg_op_r;
  logic          stg_last_r;
  logic [SAMPLE_WIDTH-1:0] stg_s0_r, stg_s1_r;
  logic          out_vld_r, out_last_r;
  cmd_t          cmd;

  logic [3:0][PW-1:0] red_in, red_out;
  logic [PW-1:0] wp_raw, rp_raw, push_cur, pull_cur, slot;
  logic [PW-1:0] mem_addr;
  logic          mem_we, mem_re;
  logic [DW-1:0] mem_wdata, mem_rdata;

  // a config word goes ahead of a start in the same cycle
  assign busy      = (state_r != ST_IDLE) || cfg_valid;
  assign cfg_ready = (state_r == ST_CLEAR) || (state_r == ST_IDLE && !stg_vld_r);
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign red_start = cfg_wr && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    len_nxt   = len_r;
    if (cfg_wr) begin
      if (cfg_data == '0) begin
        len_nxt = LW'(1);
      end else if (32'(cfg_data) > 32'(DEPTH)) begin
        len_nxt = LW'(DEPTH);
      end else begin
        len_nxt = LW'(cfg_data);
      end
    end
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + PW'(1);
        if (clr_r == PW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (red_start) begin
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (red_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_r      <= '0;
      len_r      <= LW'(LEN_RST);
      stg_vld_r  <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      len_r      <= len_nxt;
      stg_vld_r  <= start && !busy;
      out_vld_r  <= stg_vld_r && (stg_op_r == OP_PULL);
    end
    if (start && !busy) begin
      stg_op_r   <= in_data.operation;
      stg_last_r <= in_data.last_of_group;
      stg_s0_r   <= in_data.channel_0_sample[SAMPLE_WIDTH-1:0];
      stg_s1_r   <= in_data.channel_1_sample[SAMPLE_WIDTH-1:0];
    end
    out_last_r <= stg_last_r;
  end

  assign cmd.vld  = stg_vld_r;
  assign cmd.op   = stg_op_r;
  assign cmd.last = stg_last_r;

  assign red_in[0] = wp_raw;
  assign red_in[1] = rp_raw;
  assign red_in[2] = push_cur;
  assign red_in[3] = pull_cur;

  mrb_reducer #(.NV(4), .PW(PW), .LW(LW)) u_reducer (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (red_start),
    .len     (len_r),
    .val_in  (red_in),
    .done    (red_done),
    .rem_out (red_out)
  );

  mrb_offsets #(.PW(PW), .LW(LW)) u_offsets (
    .clk      (clk),
    .rst_n    (rst_n),
    .len      (len_r),
    .cmd      (cmd),
    .red_load (red_done),
    .red_wp   (red_out[0]),
    .red_rp   (red_out[1]),
    .red_push (red_out[2]),
    .red_pull (red_out[3]),
    .wp_raw   (wp_raw),
    .rp_raw   (rp_raw),
    .push_cur (push_cur),
    .pull_cur (pull_cur),
    .slot     (slot)
  );

  logic [DW-1:0] push_word;

  generate
    if (STORE_CH > 1) begin : g_two
      assign push_word = {stg_s1_r, stg_s0_r};
      assign out_data.channel_1_word_out = WORD_W'(mem_rdata[DW-1:SAMPLE_WIDTH]);
    end else begin : g_one
      assign push_word = stg_s0_r;
      assign out_data.channel_1_word_out = '0;
    end
  endgenerate

  assign out_data.channel_0_word_out = WORD_W'(mem_rdata[SAMPLE_WIDTH-1:0]);
  assign out_data.last_out           = out_last_r;
  assign out_valid                   = out_vld_r;

  always_comb begin
    if (state_r == ST_CLEAR) begin
      mem_addr  = clr_r;
      mem_we    = 1'b1;
      mem_re    = 1'b0;
      mem_wdata = '0;
    end else begin
      mem_addr  = slot;
      mem_we    = stg_vld_r && (stg_op_r == OP_PUSH);
      mem_re    = stg_vld_r && (stg_op_r == OP_PULL);
      mem_wdata = push_word;
    end
  end

  mrb_frame_store #(.DEPTH(DEPTH), .AW(PW), .DW(DW)) u_store (
    .clk   (clk),
    .addr  (mem_addr),
    .we    (mem_we),
    .wdata (mem_wdata),
    .re    (mem_re),
    .rdata (mem_rdata)
  );

endmodule

/* sv/mrb_frame_store.sv */
module mrb_frame_store import mrb_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 64
) (
  input  logic          clk,
  input  logic [AW-1:0] addr,
  input  logic          we,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/mrb_reducer.sv */
// Restoring remainder, one dividend bit per cycle, one lane per offset.
module mrb_reducer import mrb_pkg::*; #(
  parameter int NV = 4,
  parameter int PW = 10,
  parameter int LW = 11
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [LW-1:0]          len,
  input  logic [NV-1:0][PW-1:0]  val_in,
  output logic                   done,
  output logic [NV-1:0][PW-1:0]  rem_out
);

  localparam int CW = $clog2(PW + 1);

  logic                run_r, run_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [NV-1:0][LW-1:0] rem_r, rem_nxt;
  logic [NV-1:0][PW-1:0] src_r, src_nxt;

  assign done = run_r && (cnt_r == CW'(PW));

  always_comb begin
    logic [LW:0] t;
    run_nxt = run_r;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    src_nxt = src_r;
    t       = '0;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      rem_nxt = '0;
      src_nxt = val_in;
    end else if (done) begin
      run_nxt = 1'b0;
    end else if (run_r) begin
      cnt_nxt = cnt_r + CW'(1);
      for (int i = 0; i < NV; i++) begin
        t = {rem_r[i], src_r[i][PW-1]};
        if (t >= {1'b0, len}) begin
          rem_nxt[i] = LW'(t - {1'b0, len});
        end else begin
          rem_nxt[i] = LW'(t);
        end
        src_nxt[i] = src_r[i] << 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    src_r <= src_nxt;
  end

  // remainder stays below len, which never exceeds the depth
  always_comb begin
    for (int i = 0; i < NV; i++) begin
      rem_out[i] = PW'(rem_r[i]);
    end
  end

endmodule

/* sv/mrb_offsets.sv */
// Write/read offsets, lap flag and packet cursors. Raw offsets are kept for
// the overrun compares; *_m copies are reduced mod the live length.
module mrb_offsets import mrb_pkg::*; #(
  parameter int PW = 10,
  parameter int LW = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [LW-1:0] len,
  input  cmd_t          cmd,
  input  logic          red_load,
  input  logic [PW-1:0] red_wp,
  input  logic [PW-1:0] red_rp,
  input  logic [PW-1:0] red_push,
  input  logic [PW-1:0] red_pull,
  output logic [PW-1:0] wp_raw,
  output logic [PW-1:0] rp_raw,
  output logic [PW-1:0] push_cur,
  output logic [PW-1:0] pull_cur,
  output logic [PW-1:0] slot
);

  logic [PW-1:0] wp_r, wp_nxt, wp_m_r, wp_m_nxt;
  logic [PW-1:0] rp_r, rp_nxt, rp_m_r, rp_m_nxt;
  logic [PW-1:0] push_r, push_nxt, pull_r, pull_nxt;
  logic          lap_r, lap_nxt;

  logic [LW:0]   len_x;
  logic [LW:0]   push_inc, pull_inc, wsum, rsum, nsum, rnsum, cnt;
  logic [PW-1:0] push_adv, pull_adv, wslot, rslot, n, rp_new;
  logic          e, jump, lap_push;

  function automatic logic [LW:0] wrap(input logic [LW:0] v, input logic [LW:0] l);
    wrap = (v >= l) ? (v - l) : v;
  endfunction

  always_comb begin
    len_x    = {1'b0, len};
    push_inc = (LW+1)'(push_r) + (LW+1)'(1);
    pull_inc = (LW+1)'(pull_r) + (LW+1)'(1);
    push_adv = (push_inc == len_x) ? '0 : PW'(push_inc);
    pull_adv = (pull_inc == len_x) ? '0 : PW'(pull_inc);
    wsum     = (LW+1)'(wp_m_r) + (LW+1)'(push_r);
    rsum     = (LW+1)'(rp_m_r) + (LW+1)'(pull_r);
    wslot    = PW'(wrap(wsum, len_x));
    rslot    = PW'(wrap(rsum, len_x));
    cnt      = (cmd.op == OP_PUSH) ? (LW+1)'(push_adv) : '0;
    nsum     = (LW+1)'(wp_m_r) + cnt;
    n        = PW'(wrap(nsum, len_x));
    rnsum    = (LW+1)'(rp_m_r) + (LW+1)'(pull_adv);
    rp_new   = PW'(wrap(rnsum, len_x));
    e        = lap_r && (wp_r == rp_r);
    jump     = ((wp_r > rp_r || e) && n > rp_r && n < wp_r) ||
               ((wp_r < rp_r || e) && ((n < rp_r && n < wp_r) || n > rp_r));
    lap_push = (n <= rp_r) && (wp_r > rp_r || wp_r < n);
  end

  assign slot = (cmd.op == OP_PULL) ? rslot : wslot;

  always_comb begin
    wp_nxt   = wp_r;
    wp_m_nxt = wp_m_r;
    rp_nxt   = rp_r;
    rp_m_nxt = rp_m_r;
    push_nxt = push_r;
    pull_nxt = pull_r;
    lap_nxt  = lap_r;
    if (red_load) begin
      wp_m_nxt = red_wp;
      rp_m_nxt = red_rp;
      push_nxt = red_push;
      pull_nxt = red_pull;
    end else if (cmd.vld) begin
      case (cmd.op)
        OP_PUSH, OP_EMPTY: begin
          push_nxt = push_adv;
          if (cmd.op == OP_EMPTY || cmd.last) begin
            wp_nxt   = n;
            wp_m_nxt = n;
            if (jump) begin
              rp_nxt   = n;
              rp_m_nxt = n;
            end
            lap_nxt  = lap_push;
            push_nxt = '0;
          end
        end
        OP_PULL: begin
          pull_nxt = pull_adv;
          if (cmd.last) begin
            rp_nxt   = rp_new;
            rp_m_nxt = rp_new;
            lap_nxt  = rp_new > wp_r;
            pull_nxt = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      wp_m_r <= '0;
      rp_r   <= '0;
      rp_m_r <= '0;
      push_r <= '0;
      pull_r <= '0;
      lap_r  <= 1'b0;
    end else begin
      wp_r   <= wp_nxt;
      wp_m_r <= wp_m_nxt;
      rp_r   <= rp_nxt;
      rp_m_r <= rp_m_nxt;
      push_r <= push_nxt;
      pull_r <= pull_nxt;
      lap_r  <= lap_nxt;
    end
  end

  assign wp_raw   = wp_r;
  assign rp_raw   = rp_r;
  assign push_cur = push_r;
  assign pull_cur = pull_r;

endmodule

/* test/tb_multichannel_overwrite_ring_buffer.sv */
module tb_multichannel_overwrite_ring_buffer;
  import mrb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RING_DEPTH = 1024;
  localparam int unsigned RAND_ITEMS = 1500;
  localparam int unsigned RUN_LIMIT  = 300000;
  localparam logic [1:0]  OP_UNUSED  = 2'd3;

  typedef enum logic {ROW_WORD, ROW_LEN} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [1:0]       op;
    logic [31:0]      w0;
    logic [31:0]      w1;
    logic             last;
    logic             typed;
    logic [31:0]      x0;
    logic [31:0]      x1;
    logic [CFG_W-1:0] len_val;
  } dir_row_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_item_t         in_data;
  logic             out_valid;
  out_item_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  // ring state as seen from outside
  bit [31:0]        ch0_slots [RING_DEPTH];
  bit [31:0]        ch1_slots [RING_DEPTH];
  int unsigned      wr_ofs;
  int unsigned      rd_ofs;
  int unsigned      push_cnt;
  int unsigned      pull_cnt;
  bit               lap;
  logic [CFG_W-1:0] ring_len_reg;

  out_item_t        pulled_frames_q [$];
  out_item_t        front_frame;
  int unsigned      mismatches;
  int unsigned      cycle_count;
  bit               steady;

  // typed results only where the ring contents are obvious
  dir_row_t dir_rows [25] = '{
    '{ROW_WORD, OP_PULL,   32'h0,        32'h0,        1'b0, 1'b1, 32'h0, 32'h0, 11'd0},
    '{ROW_WORD, OP_PULL,   32'h0,        32'h0,        1'b1, 1'b1, 32'h0, 32'h0, 11'd0},
    '{ROW_WORD, OP_PUSH,   32'hFFFFFFFF, 32'h00000000, 1'b0, 1'b0, 32'h0, 32'h0, 11'd0},
    '{ROW_WORD, OP_PUSH,   32'h00000000, 32'hFFFFFFFF, 1'b0, 1'b0, 32'h0, 32'h0, 11'd0},
    // overwrites an unread slot, reader jumps
    '{ROW_WORD, OP_PUSH,   32'hA5A5A5A5, 32'h5A5A5A5A, 1'b1, 1'b0, 32'h0, 32'h0, 11'd0},
    '{ROW_WORD, OP_EMPTY,  32'h0,        32'h0,        1'b0, 1'b0, 32'h0, 32'h0, 11'd0},
    '{ROW_WORD, OP_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b0, 32'h0, 32'h0, 11'd0},
    '{ROW_WORD, OP_PULL,   32'h0,        32'h0,        1'b1, 1'b1, 32'h0, 32'h0, 11'd0},
    // writer catches up with the reader: lap set
    '{ROW_WORD, OP_PUSH,   32'h12345678, 32'h9ABCDEF0, 1'b1, 1'b0, 32'h0, 32'h0, 11'd0},
    '{ROW_WORD, OP_PUSH,   32'hDEADBEEF, 32'h01234567, 1'b1, 1'b0, 32'h0, 32'h0, 11'd0},
    // zero length acts as one slot
    '{ROW_LEN,  OP_PUSH,   32'h0,        32'h0,        1'b0, 1'b0, 32'h0, 32'h0, 11'd0},
    '{ROW_WORD, OP_PUSH,   32'h00000000, 32'hFFFFFFFF, 1'b0, 1'b0, 32'h0, 32'h0, 11'd0},
    '{ROW_WORD, OP_PUSH,   32'hFFFFFFFF, 32'h00000000, 1'b1, 1'b0, 32'h0, 32'h0, 11'd0},
    '{ROW_WORD, OP_PULL,   32'h0,        32'h0,        1'b1, 1'b1,
      32'hFFFFFFFF, 32'h00000000, 11'd0},
    '{ROW_LEN,  OP_PUSH,   32'h0,        32'h0,        1'b0, 1'b0, 32'h0, 32'h0, 11'd2047},
    '{ROW_WORD, OP_PULL,   32'h0,        32'h0,        1'b0, 1'b0, 32'h0, 32'h0, 11'd0},
    '{ROW_WORD, OP_PULL,   32'h0,        32'h0,        1'b1, 1'b0, 32'h0, 32'h0, 11'd0},
    '{ROW_LEN,  OP_PUSH,   32'h0,        32'h0,        1'b0, 1'b0, 32'h0, 32'h0, 11'd2},
    // packet of exactly one lap
    '{ROW_WORD, OP_PUSH,   32'h0F0F0F0F, 32'hF0F0F0F0, 1'b0, 1'b0, 32'h0, 32'h0, 11'd0},
    '{ROW_WORD, OP_PUSH,   32'h80000000, 32'h00000001, 1'b1, 1'b0, 32'h0, 32'h0, 11'd0},
    '{ROW_WORD, OP_PUSH,   32'h7FFFFFFF, 32'hFFFFFFFE, 1'b1, 1'b0, 32'h0, 32'h0, 11'd0},
    '{ROW_WORD, OP_PULL,   32'h0,        32'h0,        1'b0, 1'b0, 32'h0, 32'h0, 11'd0},
    '{ROW_WORD, OP_PULL,   32'h0,        32'h0,        1'b1, 1'b0, 32'h0, 32'h0, 11'd0},
    // empty packet drops the pending frame count
    '{ROW_WORD, OP_PUSH,   32'h13579BDF, 32'h2468ACE0, 1'b0, 1'b0, 32'h0, 32'h0, 11'd0},
    '{ROW_WORD, OP_EMPTY,  32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b0, 32'h0, 32'h0, 11'd0}
  };

  multichannel_overwrite_ring_buffer #(
    .DEPTH        (RING_DEPTH),
    .CHANNELS     (2),
    .SAMPLE_WIDTH (32)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned live_len();
    if (ring_len_reg == 0) return 1;
    if (ring_len_reg > RING_DEPTH) return RING_DEPTH;
    return 32'(ring_len_reg);
  endfunction

  function automatic void commit_push_offsets(input int unsigned count, input int unsigned len);
    int unsigned o;
    int unsigned r;
    int unsigned n;
    bit          e;
    bit          jump;
    o = wr_ofs;
    r = rd_ofs;
    n = (o + count) % len;
    e = lap && (o == r);
    jump = ((o > r || e) && n > r && n < o) ||
           ((o < r || e) && ((n < r && n < o) || n > r));
    wr_ofs = n;
    if (jump) rd_ofs = n;
    lap = (n <= r) && (o > r || o < n);
    push_cnt = 0;
  endfunction

  function automatic void advance_ring(input in_item_t w, output bit has_frame,
                                       output out_item_t frame);
    int unsigned len;
    int unsigned slot;
    len = live_len();
    has_frame = 1'b0;
    frame = '0;
    case (w.operation)
      OP_PUSH: begin
        slot = (wr_ofs + push_cnt) % len;
        ch0_slots[slot] = w.channel_0_sample;
        ch1_slots[slot] = w.channel_1_sample;
        push_cnt = (push_cnt + 1) % len;
        if (w.last_of_group) commit_push_offsets(push_cnt, len);
      end
      OP_EMPTY: begin
        commit_push_offsets(0, len);
      end
      OP_PULL: begin
        slot = (rd_ofs + pull_cnt) % len;
        has_frame = 1'b1;
        frame.channel_0_word_out = ch0_slots[slot];
        frame.channel_1_word_out = ch1_slots[slot];
        frame.last_out = w.last_of_group;
        pull_cnt = (pull_cnt + 1) % len;
        if (w.last_of_group) begin
          rd_ofs = (rd_ofs + pull_cnt) % len;
          lap = rd_ofs > wr_ofs;
          pull_cnt = 0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic in_item_t frame_word(input logic [1:0] op, input logic last);
    in_item_t w;
    w.operation = op;
    w.channel_0_sample = $urandom;
    w.channel_1_sample = $urandom;
    w.last_of_group = last;
    return w;
  endfunction

  task automatic send_word(input in_item_t w, input bit typed, input out_item_t want);
    bit        has_frame;
    out_item_t frame;
    start <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
    advance_ring(w, has_frame, frame);
    if (has_frame) pulled_frames_q.push_back(typed ? want : frame);
  endtask

  task automatic idle_gap();
    if (!steady && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // length is only changed with nothing in flight
  task automatic settle_and_write_len(input logic [CFG_W-1:0] v);
    start <= 1'b0;
    while (pulled_frames_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ring_len_reg = v;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pulled_frames_q.size() == 0) begin
        $display("%0t: unexpected word, got %h", $time, out_data);
        mismatches++;
      end else begin
        front_frame = pulled_frames_q.pop_front();
        if (out_data.channel_0_word_out !== front_frame.channel_0_word_out) begin
          $display("%0t: channel_0_word_out expected %h got %h", $time,
                   front_frame.channel_0_word_out, out_data.channel_0_word_out);
          mismatches++;
        end
        if (out_data.channel_1_word_out !== front_frame.channel_1_word_out) begin
          $display("%0t: channel_1_word_out expected %h got %h", $time,
                   front_frame.channel_1_word_out, out_data.channel_1_word_out);
          mismatches++;
        end
        if (out_data.last_out !== front_frame.last_out) begin
          $display("%0t: last_out expected %b got %b", $time,
                   front_frame.last_out, out_data.last_out);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("timeout at %0t, %0d words still expected", $time, pulled_frames_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int unsigned      sent;
    int unsigned      phase_end;
    int unsigned      phase_no;
    int unsigned      len;
    int unsigned      k;
    int unsigned      j;
    int unsigned      pick;
    logic [1:0]       op;
    logic [CFG_W-1:0] new_len;

    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    mismatches = 0;
    cycle_count = 0;
    steady = 1'b0;
    wr_ofs = 0;
    rd_ofs = 0;
    push_cnt = 0;
    pull_cnt = 0;
    lap = 1'b0;
    ring_len_reg = 11'd1024;
    foreach (ch0_slots[i]) begin
      ch0_slots[i] = '0;
      ch1_slots[i] = '0;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_LEN) begin
        settle_and_write_len(dir_rows[i].len_val);
      end else begin
        idle_gap();
        send_word('{dir_rows[i].op, dir_rows[i].w0, dir_rows[i].w1, dir_rows[i].last},
                  dir_rows[i].typed,
                  '{dir_rows[i].x0, dir_rows[i].x1, dir_rows[i].last});
      end
    end

    sent = 0;
    phase_no = 0;
    while (sent < RAND_ITEMS) begin
      if (phase_no < 2) begin
        new_len = (phase_no == 0) ? 11'd1024 : 11'd1;
      end else begin
        case ($urandom_range(0, 9))
          0:       new_len = 11'd0;
          1:       new_len = 11'd1;
          2:       new_len = 11'd1024;
          3:       new_len = 11'd2047;
          4:       new_len = CFG_W'($urandom_range(1025, 2047));
          8:       new_len = CFG_W'($urandom_range(9, 64));
          9:       new_len = CFG_W'($urandom_range(1, 1024));
          default: new_len = CFG_W'($urandom_range(2, 8));
        endcase
      end
      settle_and_write_len(new_len);
      phase_no++;
      len = live_len();
      phase_end = sent + $urandom_range(40, 150);
      while (sent < phase_end && sent < RAND_ITEMS) begin
        steady = sent + 200 >= RAND_ITEMS;
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
          op = (pick < 45) ? OP_PUSH : OP_PULL;
          case ($urandom_range(0, 9))
            0:       k = len;
            1:       k = len + 1;
            default: k = $urandom_range(1, (len < 6) ? len : 6);
          endcase
          // whole-lap packets only on short rings
          if (k > 65) k = $urandom_range(1, 6);
          for (j = 1; j <= k; j++) begin
            idle_gap();
            send_word(frame_word(op, j == k), 1'b0, '0);
          end
          sent += k;
        end else if (pick < 90) begin
          idle_gap();
          send_word(frame_word(OP_EMPTY, 1'($urandom_range(0, 1))), 1'b0, '0);
          sent++;
        end else begin
          // stray word: random code, unused code included, with a random last flag
          op = 2'($urandom_range(0, 3));
          idle_gap();
          send_word(frame_word(op, 1'($urandom_range(0, 1))), 1'b0, '0);
          if (op != OP_UNUSED) sent++;
        end
      end
    end

    start <= 1'b0;
    while (pulled_frames_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
